/* design/tbsg_pkg.sv */
`default_nettype none
package tbsg_pkg;

	localparam int DIM_W     = 32;
	localparam int STRIDE_W  = 63;
	localparam int DIMS_W    = 4;
	localparam int MAX_RANK  = 8;
	localparam logic [DIMS_W-1:0] DIMS_MAX = {DIMS_W{1'b1}};

	localparam int S_TDATA_W = 2 * DIM_W;
	localparam int M_FIELD_W = DIM_W + 2 * STRIDE_W + 4;
	localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [DIM_W-1:0]    DIM_ONE    = {{(DIM_W-1){1'b0}}, 1'b1};
	localparam logic [STRIDE_W-1:0] STRIDE_ONE = {{(STRIDE_W-1){1'b0}}, 1'b1};
	localparam logic [STRIDE_W-1:0] STRIDE_SAT = {STRIDE_W{1'b1}};

	typedef struct packed {
		logic [DIM_W-1:0] dim_a;
		logic [DIM_W-1:0] dim_b;
		logic [DIM_W-1:0] out_dim;
		logic             a_gt1;
		logic             b_gt1;
		logic             bcast_a;
		logic             bcast_b;
		logic             mism;
		logic             first;
		logic             last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

	// Saturating product of a 63-bit count and a 32-bit size, built from a 32x32 and a
	// 31x32 partial product that work side by side.
	function automatic logic [STRIDE_W-1:0] sat_mul(input logic [STRIDE_W-1:0] x,
			input logic [DIM_W-1:0] y);
		logic [2*DIM_W-1:0]    lo;
		logic [STRIDE_W-1:0]   hi;
		logic [STRIDE_W:0]     mid;
		logic [STRIDE_W-1:0]   res;
		lo  = {{DIM_W{1'b0}}, x[DIM_W-1:0]} * {{DIM_W{1'b0}}, y};
		hi  = {{DIM_W{1'b0}}, x[STRIDE_W-1:DIM_W]} * {{(STRIDE_W-DIM_W){1'b0}}, y};
		mid = {1'b0, hi} + {{(STRIDE_W+1-DIM_W){1'b0}}, lo[2*DIM_W-1:DIM_W]};
		if (|mid[STRIDE_W:STRIDE_W-DIM_W]) begin
			res = STRIDE_SAT;
		end else begin
			res = {mid[STRIDE_W-DIM_W-1:0], lo[DIM_W-1:0]};
		end
		return res;
	endfunction

endpackage
`default_nettype wire

/* design/tbsg_front.sv */
`default_nettype none
module tbsg_front (
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [tbsg_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                           s_tuser,
	input  wire logic                           s_tlast,
	input  wire tbsg_pkg::q_status_t            q_status,
	output logic                                q_push,
	output tbsg_pkg::q_entry_t                  q_entry
);

	logic [tbsg_pkg::DIM_W-1:0] dim_a;
	logic [tbsg_pkg::DIM_W-1:0] dim_b;
	logic [tbsg_pkg::DIM_W-1:0] out_dim;

	assign dim_a   = s_tdata[tbsg_pkg::DIM_W-1:0];
	assign dim_b   = s_tdata[2*tbsg_pkg::DIM_W-1:tbsg_pkg::DIM_W];
	assign out_dim = (dim_a > dim_b) ? dim_a : dim_b;

	assign s_tready = !q_status.full;
	assign q_push   = s_tvalid && !q_status.full;

	always_comb begin
		q_entry.dim_a   = dim_a;
		q_entry.dim_b   = dim_b;
		q_entry.out_dim = out_dim;
		q_entry.a_gt1   = dim_a > tbsg_pkg::DIM_ONE;
		q_entry.b_gt1   = dim_b > tbsg_pkg::DIM_ONE;
		q_entry.bcast_a = (dim_a == tbsg_pkg::DIM_ONE) && (out_dim > tbsg_pkg::DIM_ONE);
		q_entry.bcast_b = (dim_b == tbsg_pkg::DIM_ONE) && (out_dim > tbsg_pkg::DIM_ONE);
		q_entry.mism    = (dim_a != dim_b) && (dim_a != tbsg_pkg::DIM_ONE)
			&& (dim_b != tbsg_pkg::DIM_ONE);
		q_entry.first   = s_tuser;
		q_entry.last    = s_tlast;
	end

endmodule
`default_nettype wire

/* design/tbsg_fifo.sv */
`default_nettype none
module tbsg_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tbsg_pkg::q_entry_t entry_in,
	input  wire logic               pop,
	output tbsg_pkg::q_entry_t      entry_out,
	output tbsg_pkg::q_status_t     status
);

	tbsg_pkg::q_entry_t mem_q [tbsg_pkg::QDEPTH];
	logic [tbsg_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tbsg_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tbsg_pkg::QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign status.full  = count_q == tbsg_pkg::QCNT_W'(tbsg_pkg::QDEPTH);
	assign status.valid = count_q != '0;
	assign do_push = push && !status.full;
	assign do_pop  = pop && status.valid;
	assign entry_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tbsg_pkg::QPTR_W'(tbsg_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tbsg_pkg::QPTR_W'(tbsg_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/tbsg_back.sv */
`default_nettype none
module tbsg_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tbsg_pkg::q_entry_t             q_entry,
	input  wire tbsg_pkg::q_status_t            q_status,
	output logic                                q_pop,
	output logic                                s1_valid,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [tbsg_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tlast
);

	logic [tbsg_pkg::STRIDE_W-1:0] run_prod_a_q, run_prod_b_q;
	logic [tbsg_pkg::STRIDE_W-1:0] count_a_q, count_b_q, count_out_q;
	logic [tbsg_pkg::DIMS_W-1:0]   dims_seen_q;
	logic                          mism_q, ovf_q, restart_q;

	logic [tbsg_pkg::STRIDE_W-1:0] pa, pb, ca, cb, co;
	logic [tbsg_pkg::DIMS_W-1:0]   dims;
	logic                          mism, ovf, clr;
	logic [tbsg_pkg::STRIDE_W-1:0] ca_n, cb_n, co_n;
	logic                          mism_n, ovf_n;

	logic                          s1_valid_q;
	logic [tbsg_pkg::DIM_W-1:0]    out_dim_s1;
	logic [tbsg_pkg::STRIDE_W-1:0] a_stride_s1, b_stride_s1;
	logic [tbsg_pkg::STRIDE_W-1:0] count_a_s1, count_b_s1, count_out_s1;
	logic                          mism_s1, ovf_s1, last_s1;

	logic                          m_tvalid_q;
	logic [tbsg_pkg::M_TDATA_W-1:0] tdata_s2;
	logic                          tlast_s2;

	logic s2_ready, s1_ready, s1_move;

	assign s2_ready = !m_tvalid_q || m_tready;
	assign s1_ready = !s1_valid_q || s2_ready;
	assign q_pop    = q_status.valid && s1_ready;
	assign s1_move  = s1_valid_q && s2_ready;

	// A word that opens a pair, or follows the end of one, sees reset state.
	assign clr  = q_entry.first || restart_q;
	assign pa   = clr ? tbsg_pkg::STRIDE_ONE : run_prod_a_q;
	assign pb   = clr ? tbsg_pkg::STRIDE_ONE : run_prod_b_q;
	assign ca   = clr ? tbsg_pkg::STRIDE_ONE : count_a_q;
	assign cb   = clr ? tbsg_pkg::STRIDE_ONE : count_b_q;
	assign co   = clr ? tbsg_pkg::STRIDE_ONE : count_out_q;
	assign dims = clr ? '0 : dims_seen_q;
	assign mism = clr ? 1'b0 : mism_q;
	assign ovf  = clr ? 1'b0 : ovf_q;

	assign ovf_n  = ovf || (dims >= tbsg_pkg::DIMS_W'(tbsg_pkg::MAX_RANK));
	assign mism_n = mism || q_entry.mism;
	assign ca_n   = tbsg_pkg::sat_mul(ca, q_entry.dim_a);
	assign cb_n   = tbsg_pkg::sat_mul(cb, q_entry.dim_b);
	assign co_n   = tbsg_pkg::sat_mul(co, q_entry.out_dim);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			run_prod_a_q <= q_entry.a_gt1 ? tbsg_pkg::sat_mul(pa, q_entry.dim_a) : pa;
			run_prod_b_q <= q_entry.b_gt1 ? tbsg_pkg::sat_mul(pb, q_entry.dim_b) : pb;
			count_a_q    <= ca_n;
			count_b_q    <= cb_n;
			count_out_q  <= co_n;
			dims_seen_q  <= (dims == tbsg_pkg::DIMS_MAX) ? dims : dims + 1'b1;
			mism_q       <= mism_n;
			ovf_q        <= ovf_n;

			out_dim_s1   <= q_entry.out_dim;
			a_stride_s1  <= q_entry.bcast_a ? '0 : pa;
			b_stride_s1  <= q_entry.bcast_b ? '0 : pb;
			count_a_s1   <= ca_n;
			count_b_s1   <= cb_n;
			count_out_s1 <= co_n;
			mism_s1      <= mism_n;
			ovf_s1       <= ovf_n;
			last_s1      <= q_entry.last;
		end
		if (s1_move) begin
			tdata_s2 <= tbsg_pkg::M_TDATA_W'({
				last_s1 && (count_b_s1 < count_out_s1),
				last_s1 && (count_a_s1 < count_out_s1),
				ovf_s1, mism_s1, b_stride_s1, a_stride_s1, out_dim_s1});
			tlast_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q  <= 1'b1;
			s1_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				restart_q <= q_entry.last;
			end
			if (s1_ready) begin
				s1_valid_q <= q_pop;
			end
			if (s2_ready) begin
				m_tvalid_q <= s1_valid_q;
			end
		end
	end

	assign s1_valid = s1_valid_q;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = tdata_s2;
	assign m_tlast  = tlast_s2;

endmodule
`default_nettype wire

/* design/tensor_broadcast_stride_gen.sv */
// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  tdata: dim_a, dim_b; tuser: first; tlast: last
// m        out  m_tvalid/m_tready  tdata: out_dim, A stride, B stride, incompatible,
//                                  rank_overflow, expands_a, expands_b; tlast: end_of_shape
//
// One word per cycle is sustained while m_tready holds high; a word passes the queue, then stage 1 and stage 2.
// The per-dimension multiply into the running products is combinational, ahead of the stage 1 registers.
// Reset puts the queue and both stages empty and the next word starts a new shape.
// A four-entry queue between the classifier and the product stage lets either side stall.
`default_nettype none
module tensor_broadcast_stride_gen (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [tbsg_pkg::S_TDATA_W-1:0] s_tdata,  // dim_a, dim_b
	input  wire logic                           s_tuser,  // first
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [tbsg_pkg::M_TDATA_W-1:0]      m_tdata,  // out_dim, A stride, B stride,
	                                                      // incompatible, rank_overflow,
	                                                      // expands_a, expands_b, zero fill
	output logic                                m_tlast
);

	tbsg_pkg::q_entry_t  in_entry;
	tbsg_pkg::q_entry_t  out_entry;
	tbsg_pkg::q_status_t q_status;
	logic                q_push;
	logic                q_pop;
	logic                s1_valid;

	tbsg_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_status (q_status),
		.q_push   (q_push),
		.q_entry  (in_entry)
	);

	tbsg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (in_entry),
		.pop       (q_pop),
		.entry_out (out_entry),
		.status    (q_status)
	);

	tbsg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_entry  (out_entry),
		.q_status (q_status),
		.q_pop    (q_pop),
		.s1_valid (s1_valid),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	localparam int EXP_A_BIT = tbsg_pkg::DIM_W + 2 * tbsg_pkg::STRIDE_W + 2;

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tdata[EXP_A_BIT] && !m_tdata[EXP_A_BIT + 1])
		else $error("expansion flag raised on a word that does not end a shape");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !s_tready)
		else $error("input accepted while the queue is full");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> s1_valid)
		else $error("word taken from the queue did not reach the product stage");

endmodule
`default_nettype wire
